>>> hdl/smc_pkg.sv
// ----------------------------------------------------------------------------
// smc_pkg
// Shared constants, codes and controller/datapath interface types for the
// sample mean and covariance core.
// ----------------------------------------------------------------------------
package smc_pkg;

  localparam int MAX_POINTS  = 1024;
  localparam int MAX_DIMS    = 8;
  localparam int STORE_DEPTH = MAX_POINTS * MAX_DIMS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
  localparam int DIM_W       = 3;

  // Configuration register indexes.
  localparam logic REG_MODE = 1'b0;
  localparam logic REG_DIMS = 1'b1;

  // Mode codes.
  localparam logic [1:0] MODE_MEAN = 2'd0;
  localparam logic [1:0] MODE_VAR  = 2'd1;
  localparam logic [1:0] MODE_COV  = 2'd2;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_EMPTY   = 2'd1,
    ERR_PARTIAL = 2'd2,
    ERR_OVERFLOW = 2'd3
  } err_code_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_CLEAR,
    ACC_ADD_COORD,
    ACC_ADD_PROD
  } acc_op_t;

  typedef enum logic {
    DIV_SRC_CNT,
    DIV_SRC_ACC
  } div_src_t;

  typedef enum logic [1:0] {
    OUT_SRC_ZERO,
    OUT_SRC_MEAN,
    OUT_SRC_QUOT
  } out_src_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             load;
    logic             clear_set;
    logic [ADDR_W-1:0] addr_a;
    logic [ADDR_W-1:0] addr_b;
    acc_op_t          acc_op;
    logic             div_start;
    div_src_t         div_src;
    logic [CNT_W-1:0] div_divisor;
    logic             mean_we;
    logic [DIM_W-1:0] mean_sel;
    logic             load_mj;
    logic             load_mk;
    logic             dev_en;
    logic             mul_en;
    logic             emit;
    out_src_t         out_src;
    logic [DIM_W-1:0] out_row;
    logic [DIM_W-1:0] out_col;
    err_code_t        out_err;
    logic             out_last;
  } smc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic             full;
    logic             div_done;
    logic             div_rem_zero;
    logic [CNT_W-1:0] div_quot_lo;
    logic             out_free;
  } smc_stat_t;

endpackage

>>> hdl/smc_div.sv
// ----------------------------------------------------------------------------
// smc_div
// Serial signed-by-unsigned divider, one quotient bit per cycle, truncating
// toward zero.
// ----------------------------------------------------------------------------
module smc_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic signed [63:0]             dividend,
  input  logic [smc_pkg::CNT_W-1:0]      divisor,
  output logic                           done,
  output logic [63:0]                    quotient,
  output logic [smc_pkg::CNT_W-1:0]      remainder
);

  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic                        neg_r, neg_nxt;
  logic [5:0]                  step_r, step_nxt;
  logic [63:0]                 mag_r, mag_nxt;
  logic [smc_pkg::CNT_W-1:0]   rem_r, rem_nxt;
  logic [smc_pkg::CNT_W-1:0]   div_r, div_nxt;
  logic [smc_pkg::CNT_W:0]     trial;

  // One restoring step per cycle; the magnitude shifts out as quotient bits
  // shift in.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    neg_nxt  = neg_r;
    step_nxt = step_r;
    mag_nxt  = mag_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    trial    = {rem_r, mag_r[63]};
    if (start) begin
      busy_nxt = 1'b1;
      neg_nxt  = dividend[63];
      mag_nxt  = dividend[63] ? (64'd0 - 64'(dividend)) : 64'(dividend);
      rem_nxt  = '0;
      div_nxt  = divisor;
      step_nxt = '0;
    end else if (busy_r) begin
      if (trial >= {1'b0, div_r}) begin
        rem_nxt = smc_pkg::CNT_W'(trial - {1'b0, div_r});
        mag_nxt = {mag_r[62:0], 1'b1};
      end else begin
        rem_nxt = trial[smc_pkg::CNT_W-1:0];
        mag_nxt = {mag_r[62:0], 1'b0};
      end
      step_nxt = step_r + 6'd1;
      if (step_r == 6'd63) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    neg_r  <= neg_nxt;
    step_r <= step_nxt;
    mag_r  <= mag_nxt;
    rem_r  <= rem_nxt;
    div_r  <= div_nxt;
  end

  assign done      = done_r;
  assign quotient  = neg_r ? (64'd0 - mag_r) : mag_r;
  assign remainder = rem_r;

endmodule

>>> hdl/smc_datapath.sv
// ----------------------------------------------------------------------------
// smc_datapath
// Point store, mean registers, deviation multiplier, saturating accumulator,
// shared divider and result register.
// ----------------------------------------------------------------------------
module smc_datapath (
  input  logic                    clk,
  input  logic                    rst_n,
  input  smc_pkg::smc_cmd_t       cmd,
  output smc_pkg::smc_stat_t      stat,
  input  logic signed [31:0]      in_coordinate_value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [63:0]      out_result_value,
  output logic [2:0]              out_result_row,
  output logic [2:0]              out_result_col,
  output logic [1:0]              out_error_code,
  output logic                    out_last_result
);

  logic [31:0] mem [smc_pkg::STORE_DEPTH];
  logic [31:0] rd_a_r, rd_b_r;

  logic [smc_pkg::CNT_W-1:0] cnt_r;
  logic                      full_r;

  logic signed [31:0] mean_r [smc_pkg::MAX_DIMS];
  logic signed [31:0] mean_sel_val;
  logic signed [31:0] mj_r, mk_r;

  logic [32:0] magj_r, magk_r;
  logic        dev_neg_r;
  logic signed [32:0] dj, dk;
  logic [63:0] prod_r;
  logic        prod_neg_r;
  logic [65:0] prod_full;

  logic signed [63:0] acc_r, acc_nxt;
  logic signed [65:0] sat_sum;

  logic               div_done;
  logic [63:0]        div_quot;
  logic [smc_pkg::CNT_W-1:0] div_rem;
  logic signed [63:0] div_dividend;

  logic               out_valid_r;
  logic signed [63:0] out_value_r, out_value_nxt;
  logic [2:0]         out_row_r, out_col_r;
  logic [1:0]         out_err_r;
  logic               out_last_r;
  logic               out_free;

  // Coordinate store write and two registered read ports.
  always_ff @(posedge clk) begin
    if (cmd.load && (cnt_r < smc_pkg::CNT_W'(smc_pkg::STORE_DEPTH))) begin
      mem[cnt_r[smc_pkg::ADDR_W-1:0]] <= in_coordinate_value;
    end
    rd_a_r <= mem[cmd.addr_a];
    rd_b_r <= mem[cmd.addr_b];
  end

  // Fill count and overflow flag of the current set.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      full_r <= 1'b0;
    end else if (cmd.clear_set) begin
      cnt_r  <= '0;
      full_r <= 1'b0;
    end else if (cmd.load) begin
      if (cnt_r < smc_pkg::CNT_W'(smc_pkg::STORE_DEPTH)) begin
        cnt_r <= cnt_r + smc_pkg::CNT_W'(1);
      end else begin
        full_r <= 1'b1;
      end
    end
  end

  // Mean vector, written from the divider and read at one index a cycle.
  assign mean_sel_val = mean_r[cmd.mean_sel];

  always_ff @(posedge clk) begin
    if (cmd.mean_we) begin
      mean_r[cmd.mean_sel] <= div_quot[31:0];
    end
    if (cmd.load_mj) begin
      mj_r <= mean_sel_val;
    end
    if (cmd.load_mk) begin
      mk_r <= mean_sel_val;
    end
  end

  // Deviations from the mean, then their magnitude product.
  assign dj        = 33'($signed(rd_a_r)) - 33'(mj_r);
  assign dk        = 33'($signed(rd_b_r)) - 33'(mk_r);
  assign prod_full = magj_r * magk_r;

  always_ff @(posedge clk) begin
    if (cmd.dev_en) begin
      magj_r    <= dj[32] ? (33'd0 - 33'(dj)) : 33'(dj);
      magk_r    <= dk[32] ? (33'd0 - 33'(dk)) : 33'(dk);
      dev_neg_r <= dj[32] ^ dk[32];
    end
    if (cmd.mul_en) begin
      prod_r     <= prod_full[63:0];
      prod_neg_r <= dev_neg_r;
    end
  end

  // Accumulator: plain sum for the mean, saturating sum for the moments.
  assign sat_sum = prod_neg_r ? (66'(acc_r) - $signed({2'b00, prod_r}))
                              : (66'(acc_r) + $signed({2'b00, prod_r}));

  always_comb begin
    acc_nxt = acc_r;
    case (cmd.acc_op)
      smc_pkg::ACC_CLEAR:     acc_nxt = '0;
      smc_pkg::ACC_ADD_COORD: acc_nxt = acc_r + 64'($signed(rd_a_r));
      smc_pkg::ACC_ADD_PROD: begin
        if (sat_sum[65:63] == 3'b000 || sat_sum[65:63] == 3'b111) begin
          acc_nxt = sat_sum[63:0];
        end else if (sat_sum[65]) begin
          acc_nxt = {1'b1, 63'd0};
        end else begin
          acc_nxt = {1'b0, {63{1'b1}}};
        end
      end
      default: acc_nxt = acc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

  // Shared divider for point count, means and moments.
  assign div_dividend = (cmd.div_src == smc_pkg::DIV_SRC_CNT) ?
                        $signed({{(64-smc_pkg::CNT_W){1'b0}}, cnt_r}) : acc_r;

  smc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (div_dividend),
    .divisor   (cmd.div_divisor),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  // Result register.
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    case (cmd.out_src)
      smc_pkg::OUT_SRC_MEAN: out_value_nxt = {{16{mean_sel_val[31]}}, mean_sel_val, 16'd0};
      smc_pkg::OUT_SRC_QUOT: out_value_nxt = div_quot;
      default:               out_value_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.emit && out_free) begin
      out_value_r <= out_value_nxt;
      out_row_r   <= cmd.out_row;
      out_col_r   <= cmd.out_col;
      out_err_r   <= cmd.out_err;
      out_last_r  <= cmd.out_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_value_r;
  assign out_result_row   = out_row_r;
  assign out_result_col   = out_col_r;
  assign out_error_code   = out_err_r;
  assign out_last_result  = out_last_r;

  assign stat.full         = full_r;
  assign stat.div_done     = div_done;
  assign stat.div_rem_zero = (div_rem == '0);
  assign stat.div_quot_lo  = div_quot[smc_pkg::CNT_W-1:0];
  assign stat.out_free     = out_free;

endmodule

>>> hdl/smc_ctrl.sv
// ----------------------------------------------------------------------------
// smc_ctrl
// Configuration registers and the sequencer that walks the load, mean,
// moment and result phases.
// ----------------------------------------------------------------------------
module smc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [3:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_last_of_set,
  output smc_pkg::smc_cmd_t  cmd,
  input  smc_pkg::smc_stat_t stat
);

  typedef enum logic [4:0] {
    ST_LOAD, ST_CHECK, ST_DIVN, ST_M_INIT, ST_M_RD, ST_M_ACC, ST_M_DSTART,
    ST_M_DWAIT, ST_O_INIT, ST_E_MEAN, ST_S_MJ, ST_S_MK, ST_S_RD, ST_S_DEV,
    ST_S_MUL, ST_S_ACC, ST_S_DSTART, ST_S_DWAIT, ST_E_MOM, ST_ERR
  } state_t;

  state_t                         state_r;
  logic [1:0]                     mode_r, run_mode_r;
  logic [3:0]                     dims_r, d_r, dsat;
  logic [smc_pkg::CNT_W-1:0]      np_r, i_r;
  logic [smc_pkg::DIM_W-1:0]      j_r, k_r;
  logic [smc_pkg::ADDR_W-1:0]     addr_a_r, addr_b_r;
  smc_pkg::err_code_t             err_r;
  logic                           j_end, k_end, i_end;

  assign dsat  = (dims_r > 4'(smc_pkg::MAX_DIMS)) ? 4'(smc_pkg::MAX_DIMS) : dims_r;
  assign j_end = ({1'b0, j_r} == d_r - 4'd1);
  assign k_end = ({1'b0, k_r} == d_r - 4'd1);
  assign i_end = (i_r + smc_pkg::CNT_W'(1) == np_r);

  // Commands decoded from the current state.
  always_comb begin
    cmd             = '0;
    cmd.addr_a      = addr_a_r;
    cmd.addr_b      = addr_b_r;
    cmd.acc_op      = smc_pkg::ACC_HOLD;
    cmd.div_src     = smc_pkg::DIV_SRC_ACC;
    cmd.div_divisor = np_r;
    cmd.mean_sel    = j_r;
    cmd.out_src     = smc_pkg::OUT_SRC_ZERO;
    cmd.out_row     = j_r;
    cmd.out_col     = k_r;
    cmd.out_err     = smc_pkg::ERR_NONE;
    in_ready        = 1'b0;
    unique case (state_r)
      ST_LOAD: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_CHECK: begin
        cmd.clear_set   = 1'b1;
        cmd.div_start   = (dsat != 4'd0) && !stat.full;
        cmd.div_src     = smc_pkg::DIV_SRC_CNT;
        cmd.div_divisor = smc_pkg::CNT_W'(dsat);
      end
      ST_M_INIT:   cmd.acc_op = smc_pkg::ACC_CLEAR;
      ST_M_ACC:    cmd.acc_op = smc_pkg::ACC_ADD_COORD;
      ST_M_DSTART: cmd.div_start = 1'b1;
      ST_M_DWAIT:  cmd.mean_we = stat.div_done;
      ST_E_MEAN: begin
        cmd.emit     = 1'b1;
        cmd.out_src  = smc_pkg::OUT_SRC_MEAN;
        cmd.out_col  = j_r;
        cmd.out_last = j_end;
      end
      ST_S_MJ: cmd.load_mj = 1'b1;
      ST_S_MK: begin
        cmd.mean_sel = k_r;
        cmd.load_mk  = 1'b1;
        cmd.acc_op   = smc_pkg::ACC_CLEAR;
      end
      ST_S_DEV:    cmd.dev_en = 1'b1;
      ST_S_MUL:    cmd.mul_en = 1'b1;
      ST_S_ACC:    cmd.acc_op = smc_pkg::ACC_ADD_PROD;
      ST_S_DSTART: cmd.div_start = 1'b1;
      ST_E_MOM: begin
        cmd.emit     = 1'b1;
        cmd.out_src  = smc_pkg::OUT_SRC_QUOT;
        cmd.out_last = (run_mode_r == smc_pkg::MODE_VAR) ? j_end : (j_end && k_end);
      end
      ST_ERR: begin
        cmd.emit     = 1'b1;
        cmd.out_row  = '0;
        cmd.out_col  = '0;
        cmd.out_err  = err_r;
        cmd.out_last = 1'b1;
      end
      default: cmd.load = 1'b0;
    endcase
  end

  // State, configuration and loop counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      mode_r  <= smc_pkg::MODE_COV;
      dims_r  <= 4'd8;
    end else begin
      if (cfg_we) begin
        if (cfg_index == smc_pkg::REG_MODE) begin
          mode_r <= cfg_data[1:0];
        end else if (cfg_index == smc_pkg::REG_DIMS) begin
          dims_r <= cfg_data;
        end
      end
      unique case (state_r)
        ST_LOAD: begin
          if (in_valid && in_last_of_set) begin
            state_r <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          d_r        <= dsat;
          run_mode_r <= mode_r;
          if (dsat == 4'd0) begin
            err_r   <= smc_pkg::ERR_EMPTY;
            state_r <= ST_ERR;
          end else if (stat.full) begin
            err_r   <= smc_pkg::ERR_OVERFLOW;
            state_r <= ST_ERR;
          end else begin
            state_r <= ST_DIVN;
          end
        end
        ST_DIVN: begin
          if (stat.div_done) begin
            if (!stat.div_rem_zero) begin
              err_r   <= smc_pkg::ERR_PARTIAL;
              state_r <= ST_ERR;
            end else begin
              np_r    <= stat.div_quot_lo;
              j_r     <= '0;
              state_r <= ST_M_INIT;
            end
          end
        end
        ST_M_INIT: begin
          i_r      <= '0;
          addr_a_r <= smc_pkg::ADDR_W'(j_r);
          state_r  <= ST_M_RD;
        end
        ST_M_RD: state_r <= ST_M_ACC;
        ST_M_ACC: begin
          i_r      <= i_r + smc_pkg::CNT_W'(1);
          addr_a_r <= addr_a_r + smc_pkg::ADDR_W'(d_r);
          state_r  <= i_end ? ST_M_DSTART : ST_M_RD;
        end
        ST_M_DSTART: state_r <= ST_M_DWAIT;
        ST_M_DWAIT: begin
          if (stat.div_done) begin
            if (j_end) begin
              state_r <= ST_O_INIT;
            end else begin
              j_r     <= j_r + 3'd1;
              state_r <= ST_M_INIT;
            end
          end
        end
        ST_O_INIT: begin
          j_r     <= '0;
          k_r     <= '0;
          state_r <= (run_mode_r == smc_pkg::MODE_MEAN) ? ST_E_MEAN : ST_S_MJ;
        end
        ST_E_MEAN: begin
          if (stat.out_free) begin
            j_r     <= j_r + 3'd1;
            state_r <= j_end ? ST_LOAD : ST_E_MEAN;
          end
        end
        ST_S_MJ: begin
          i_r      <= '0;
          addr_a_r <= smc_pkg::ADDR_W'(j_r);
          addr_b_r <= smc_pkg::ADDR_W'(k_r);
          state_r  <= ST_S_MK;
        end
        ST_S_MK:  state_r <= ST_S_RD;
        ST_S_RD:  state_r <= ST_S_DEV;
        ST_S_DEV: state_r <= ST_S_MUL;
        ST_S_MUL: state_r <= ST_S_ACC;
        ST_S_ACC: begin
          i_r      <= i_r + smc_pkg::CNT_W'(1);
          addr_a_r <= addr_a_r + smc_pkg::ADDR_W'(d_r);
          addr_b_r <= addr_b_r + smc_pkg::ADDR_W'(d_r);
          state_r  <= i_end ? ST_S_DSTART : ST_S_RD;
        end
        ST_S_DSTART: state_r <= ST_S_DWAIT;
        ST_S_DWAIT: begin
          if (stat.div_done) begin
            state_r <= ST_E_MOM;
          end
        end
        ST_E_MOM: begin
          if (stat.out_free) begin
            if (run_mode_r == smc_pkg::MODE_VAR) begin
              j_r     <= j_r + 3'd1;
              k_r     <= j_r + 3'd1;
              state_r <= j_end ? ST_LOAD : ST_S_MJ;
            end else if (k_end) begin
              j_r     <= j_r + 3'd1;
              k_r     <= '0;
              state_r <= j_end ? ST_LOAD : ST_S_MJ;
            end else begin
              k_r     <= k_r + 3'd1;
              state_r <= ST_S_MJ;
            end
          end
        end
        ST_ERR: begin
          if (stat.out_free) begin
            state_r <= ST_LOAD;
          end
        end
        default: state_r <= ST_LOAD;
      endcase
    end
  end

endmodule

>>> hdl/sample_mean_covariance_core.sv
// ----------------------------------------------------------------------------
// sample_mean_covariance_core
// Stores a set of points and reports their mean, variance or covariance.
// ----------------------------------------------------------------------------
// Coordinates are taken one per cycle and written to an 8192-entry store. The
// request that carries last_of_set starts the compute phase, during which no
// input is taken: one serial division checks the point count, then each of the
// d means and each variance or covariance entry is computed in turn with the
// single store read pair, the one multiplier and the shared one-bit-per-cycle
// divider. Results leave through an output register, so one can wait for the
// consumer while the sequencer moves on to the next entry.
module sample_mean_covariance_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [3:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_coordinate_value,
  input  logic               in_last_of_set,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [63:0] out_result_value,
  output logic [2:0]         out_result_row,
  output logic [2:0]         out_result_col,
  output logic [1:0]         out_error_code,
  output logic               out_last_result
);

  smc_pkg::smc_cmd_t  cmd;
  smc_pkg::smc_stat_t stat;

  // Sequencer.
  smc_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_last_of_set (in_last_of_set),
    .cmd            (cmd),
    .stat           (stat)
  );

  // Store, arithmetic and result register.
  smc_datapath u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .in_coordinate_value (in_coordinate_value),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_result_value    (out_result_value),
    .out_result_row      (out_result_row),
    .out_result_col      (out_result_col),
    .out_error_code      (out_error_code),
    .out_last_result     (out_last_result)
  );

endmodule

>>> bench/sample_mean_covariance_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sample_mean_covariance_core_test
// Self-checking bench for the sample mean and covariance core.
// ----------------------------------------------------------------------------
// Coordinate sets are queued by the stimulus process and fed through a
// valid/ready driver with random gaps. Every accepted request updates a
// behavioral model of the point store, and each closing coordinate produces
// the mean, variance or covariance entries (or one error result) that the
// monitor then checks in order against the core's output channel.
module sample_mean_covariance_core_test;

  localparam logic [1:0] MODE_ALT = 2'd3;
  localparam int CYCLE_LIMIT = 2500000;

  typedef struct {
    logic [31:0] coord;
    logic        last;
  } coord_req_t;

  typedef struct {
    logic signed [63:0] value;
    logic [2:0]         row;
    logic [2:0]         col;
    smc_pkg::err_code_t err;
    logic               last;
  } moment_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic               cfg_index = 1'b0;
  logic [3:0]         cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [31:0] in_coordinate_value = '0;
  logic               in_last_of_set = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [63:0] out_result_value;
  logic [2:0]         out_result_row;
  logic [2:0]         out_result_col;
  logic [1:0]         out_error_code;
  logic               out_last_result;

  sample_mean_covariance_core dut (.*);

  always #6 clk = ~clk;

  // Stimulus and expectation stores.
  coord_req_t  pending_coords[$];
  moment_t     expected_moments[$];
  int          mismatches = 0;
  int          cycle_count = 0;
  int          items_queued = 0;
  bit          calm = 1'b0;
  logic        in_taken = 1'b0;
  logic        out_taken = 1'b0;

  // Behavioral copy of the core state.
  logic [31:0]        model_store [0:smc_pkg::STORE_DEPTH-1];
  int                 model_count = 0;
  bit                 model_overflow = 1'b0;
  logic signed [31:0] model_mean [0:smc_pkg::MAX_DIMS-1];
  logic [1:0]         model_mode = smc_pkg::MODE_COV;
  logic [3:0]         model_dims = 4'd8;

  function automatic longint coord_at(int pt, int d, int j);
    return longint'($signed(model_store[pt * d + j]));
  endfunction

  // Mean of deviation products, summed in a saturating 64-bit accumulator.
  function automatic longint deviation_product_mean(int np, int d, int j, int k);
    logic signed [66:0] acc;
    longint             dj, dk;
    logic [63:0]        mag;
    acc = 0;
    for (int i = 0; i < np; i++) begin
      dj = coord_at(i, d, j) - longint'(model_mean[j]);
      dk = coord_at(i, d, k) - longint'(model_mean[k]);
      mag = (dj < 0 ? -dj : dj) * (dk < 0 ? -dk : dk);
      if ((dj < 0) != (dk < 0)) acc = acc - $signed({3'b0, mag});
      else acc = acc + $signed({3'b0, mag});
      if (acc > 67'sh0_7FFF_FFFF_FFFF_FFFF) acc = 67'sh0_7FFF_FFFF_FFFF_FFFF;
      if (acc < -67'sh0_8000_0000_0000_0000) acc = -67'sh0_8000_0000_0000_0000;
    end
    return longint'(acc[63:0]) / longint'(np);
  endfunction

  function automatic void push_moment(longint v, int r, int c, smc_pkg::err_code_t e,
                                      bit l);
    moment_t m;
    m.value = v;
    m.row = r[2:0];
    m.col = c[2:0];
    m.err = e;
    m.last = l;
    expected_moments.push_back(m);
  endfunction

  // Closes the current set and queues every result it produces.
  task automatic close_set_results();
    int                 d, np;
    longint             sum;
    smc_pkg::err_code_t err;
    d = (model_dims > smc_pkg::MAX_DIMS) ? smc_pkg::MAX_DIMS : int'(model_dims);
    err = smc_pkg::ERR_NONE;
    if (d == 0) err = smc_pkg::ERR_EMPTY;
    else if (model_overflow) err = smc_pkg::ERR_OVERFLOW;
    else if (model_count % d != 0) err = smc_pkg::ERR_PARTIAL;
    np = (d == 0) ? 0 : model_count / d;
    model_count = 0;
    model_overflow = 1'b0;
    if (err != smc_pkg::ERR_NONE) begin
      push_moment(0, 0, 0, err, 1'b1);
      return;
    end
    for (int j = 0; j < d; j++) begin
      sum = 0;
      for (int i = 0; i < np; i++) sum += coord_at(i, d, j);
      model_mean[j] = 32'(sum / longint'(np));
    end
    for (int j = 0; j < d; j++) begin
      if (model_mode == smc_pkg::MODE_MEAN)
        push_moment(longint'(model_mean[j]) * 65536, j, j, smc_pkg::ERR_NONE,
                    j == d - 1);
      else if (model_mode == smc_pkg::MODE_VAR)
        push_moment(deviation_product_mean(np, d, j, j), j, j, smc_pkg::ERR_NONE,
                    j == d - 1);
      else
        for (int k = 0; k < d; k++)
          push_moment(deviation_product_mean(np, d, j, k), j, k, smc_pkg::ERR_NONE,
                      j == d - 1 && k == d - 1);
    end
  endtask

  // Model update on accepted requests, checking of accepted results.
  always @(posedge clk) begin
    moment_t want;
    cycle_count <= cycle_count + 1;
    in_taken <= in_valid && in_ready;
    out_taken <= out_valid && out_ready;
    if (rst_n && in_valid && in_ready) begin
      if (model_count < smc_pkg::STORE_DEPTH) begin
        model_store[model_count] = in_coordinate_value;
        model_count++;
      end else begin
        model_overflow = 1'b1;
      end
      if (in_last_of_set) close_set_results();
    end
    if (rst_n && out_valid && out_ready) begin
      if (expected_moments.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: value %0d row %0d col %0d err %0d last %0d",
                   out_result_value, out_result_row, out_result_col,
                   out_error_code, out_last_result);
      end else begin
        want = expected_moments.pop_front();
        if (out_result_value !== want.value || out_result_row !== want.row ||
            out_result_col !== want.col || out_error_code !== want.err ||
            out_last_result !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d",
                     want.value, want.row, want.col, want.err, want.last,
                     out_result_value, out_result_row, out_result_col,
                     out_error_code, out_last_result);
        end
      end
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("sample_mean_covariance_core_test: done, errors");
      $finish;
    end
  end

  // Request driver: a random pause after each accepted request.
  always @(negedge clk) begin
    int         in_wait;
    coord_req_t req;
    logic       next_valid;
    if (rst_n && !(in_valid && !in_taken)) begin
      if (in_valid && in_taken) in_wait = calm ? 0 : $urandom_range(0, 12);
      next_valid = 1'b0;
      if (in_wait > 0) begin
        in_wait--;
      end else if (pending_coords.size() != 0) begin
        req = pending_coords.pop_front();
        in_coordinate_value <= req.coord;
        in_last_of_set <= req.last;
        next_valid = 1'b1;
      end
      in_valid <= next_valid;
    end
  end

  // Result sink: random stall after each accepted result.
  always @(negedge clk) begin
    int out_wait;
    if (rst_n) begin
      if (out_taken) out_wait = calm ? 0 : $urandom_range(0, 12);
      if (out_wait > 0) begin
        out_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic wait_idle();
    wait (pending_coords.size() == 0 && !in_valid && expected_moments.size() == 0);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [3:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    if (idx == smc_pkg::REG_MODE) model_mode = value[1:0];
    else model_dims = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(logic [1:0] m, logic [3:0] d);
    wait_idle();
    write_reg(smc_pkg::REG_MODE, {2'b00, m});
    write_reg(smc_pkg::REG_DIMS, d);
  endtask

  function automatic logic [31:0] draw_coord();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'($signed($urandom_range(0, 2000)) - 1000);
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_coord(logic [31:0] v, logic l);
    coord_req_t r;
    r.coord = v;
    r.last = l;
    pending_coords.push_back(r);
    items_queued++;
  endtask

  task automatic queue_set(int n);
    for (int i = 0; i < n; i++) queue_coord(draw_coord(), i == n - 1);
  endtask

  initial begin
    int d, n;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Default covariance with two opposite extreme points drives the sums near the 64-bit limit.
    for (int i = 0; i < 8; i++) queue_coord(32'h7FFF_FFFF, 1'b0);
    for (int i = 0; i < 8; i++) queue_coord(32'h8000_0000, i == 7);
    // Mean of a single coordinate, then a partial point, then no usable dims.
    set_config(smc_pkg::MODE_MEAN, 4'd1);
    queue_coord(32'hFFFF_FFFF, 1'b1);
    set_config(smc_pkg::MODE_VAR, 4'd3);
    queue_set(4);
    set_config(smc_pkg::MODE_VAR, 4'd0);
    queue_coord(32'h0000_0001, 1'b1);
    // Mode three acts as covariance and dims above MAX_DIMS clamp.
    set_config(MODE_ALT, 4'd15);
    queue_set(8);
    // A full store drops the rest of the set and flags overflow.
    set_config(smc_pkg::MODE_MEAN, 4'd8);
    for (int i = 0; i <= smc_pkg::STORE_DEPTH; i++)
      queue_coord($urandom, i == smc_pkg::STORE_DEPTH);
    items_queued -= smc_pkg::STORE_DEPTH;

    // Random sets of random shape under changing settings.
    while (items_queued < 400) begin
      if ($urandom_range(0, 2) == 0) begin
        d = $urandom_range(0, 12) == 0 ? $urandom_range(0, 15) : $urandom_range(1, 8);
        set_config(2'($urandom_range(0, 3)), 4'(d));
      end
      calm = ($urandom_range(0, 3) == 0);
      d = (model_dims > smc_pkg::MAX_DIMS) ? smc_pkg::MAX_DIMS : int'(model_dims);
      if (d == 0) d = 1;
      n = d * $urandom_range(1, 6);
      if ($urandom_range(0, 6) == 0) n = n + ($urandom_range(0, 1) ? 1 : -1);
      if (n < 1) n = 1;
      queue_set(n);
      wait (pending_coords.size() == 0);
    end

    wait_idle();
    if (mismatches == 0 && expected_moments.size() == 0)
      $display("sample_mean_covariance_core_test: done, clean");
    else
      $display("sample_mean_covariance_core_test: done, errors");
    $finish;
  end

endmodule
